// File: rtl/vga_graphics_write_path_top_assert.svh
`ifndef VGA_GRAPHICS_WRITE_PATH_TOP_ASSERT_SVH
`define VGA_GRAPHICS_WRITE_PATH_TOP_ASSERT_SVH

// Checks that a property holds on every rising edge outside reset.
`define VGW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("write path check failed");

// Checks that a condition implies another in the same cycle outside reset.
`define VGW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `VGW_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// File: rtl/vgw_pkg.sv
package vgw_pkg;

  localparam int unsigned NumPlanes  = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned CpuAddrW   = 17;
  localparam int unsigned MapAddrW   = 16;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = 8;
  localparam logic [ByteW-1:0] BitMaskReset = 8'hFF;

  typedef enum logic [1:0] {
    WrMode0 = 2'd0,
    WrMode1 = 2'd1,
    WrMode2 = 2'd2,
    WrMode3 = 2'd3
  } wr_mode_e;

  typedef enum logic [1:0] {
    AluNone = 2'd0,
    AluAnd  = 2'd1,
    AluOr   = 2'd2,
    AluXor  = 2'd3
  } alu_op_e;

  typedef enum logic [CfgIndexW-1:0] {
    CfgWriteMode      = 3'd0,
    CfgSetResetValue  = 3'd1,
    CfgSetResetEnable = 3'd2,
    CfgRotateFunction = 3'd3,
    CfgBitMask        = 3'd4,
    CfgSeqMemMode     = 3'd5,
    CfgGraphicsMisc   = 3'd6,
    CfgPageSelect     = 3'd7
  } cfg_index_e;

  typedef struct packed {
    logic [CpuAddrW-1:0]        cpu_address;
    logic [ByteW-1:0]           cpu_data;
    logic [NumPlanes*ByteW-1:0] latch_bytes;
  } in_t;

  typedef struct packed {
    logic [MapAddrW-1:0]        map_address;
    logic [NumPlanes-1:0]       plane_enables;
    logic [NumPlanes*ByteW-1:0] plane_bytes;
  } out_t;

  // Shared controls for every plane lane.
  typedef struct packed {
    logic [ByteW-1:0] fill;
    logic [ByteW-1:0] mask;
    alu_op_e          op;
  } lane_ctrl_t;

  // Addressing controls for the plane select and chaining mux.
  typedef struct packed {
    logic [3:0] seq_mode;
    logic [3:0] misc;
    logic       page_select;
  } addr_cfg_t;

endpackage

// File: rtl/vgw_lane.sv
module vgw_lane (
  input  vgw_pkg::lane_ctrl_t       ctrl_i,
  input  logic                      sr_val_i,
  input  logic                      sr_en_i,
  input  logic [vgw_pkg::ByteW-1:0] latch_i,
  output logic [vgw_pkg::ByteW-1:0] byte_o
);
  import vgw_pkg::*;

  logic [ByteW-1:0] src;
  logic [ByteW-1:0] alu;

  always_comb begin
    src = sr_en_i ? {ByteW{sr_val_i}} : ctrl_i.fill;
    case (ctrl_i.op)
      AluAnd:  alu = src & latch_i;
      AluOr:   alu = src | latch_i;
      AluXor:  alu = src ^ latch_i;
      default: alu = src;
    endcase
  end

  assign byte_o = (latch_i & ~ctrl_i.mask) | (alu & ctrl_i.mask);

endmodule

// File: rtl/vgw_addr.sv
module vgw_addr (
  input  vgw_pkg::addr_cfg_t           cfg_i,
  input  logic [vgw_pkg::CpuAddrW-1:0] cpu_address_i,
  output logic [vgw_pkg::MapAddrW-1:0] map_address_o,
  output logic [vgw_pkg::NumPlanes-1:0] plane_enables_o
);
  import vgw_pkg::*;

  logic chain4;
  logic ext_mem;
  logic sequential;

  assign chain4     = cfg_i.seq_mode[3];
  assign sequential = cfg_i.seq_mode[2];
  assign ext_mem    = cfg_i.seq_mode[1];

  always_comb begin
    if (chain4) begin
      map_address_o = {cpu_address_i[15:2], cpu_address_i[15:14]};
    end else if (!cfg_i.misc[1]) begin
      map_address_o = cpu_address_i[15:0];
    end else if (cfg_i.misc[3:2] == 2'b00) begin
      map_address_o = ext_mem ? {cpu_address_i[15:1], cpu_address_i[16]}
                              : cpu_address_i[15:0];
    end else if (ext_mem) begin
      map_address_o = {cpu_address_i[15:1], ~cfg_i.page_select};
    end else begin
      map_address_o = {cpu_address_i[15:1], cpu_address_i[14]};
    end
  end

  always_comb begin
    if (chain4) begin
      plane_enables_o = NumPlanes'(1) << cpu_address_i[1:0];
    end else if (sequential) begin
      plane_enables_o = '1;
    end else begin
      plane_enables_o = cpu_address_i[0] ? 4'b1010 : 4'b0101;
    end
  end

endmodule

// File: rtl/vga_graphics_write_path_top.sv
// VGA graphics write path: one CPU byte write can be taken in every cycle.
// The result strobe rises in the cycle after the transfer.
// Throughput is one write per cycle; four plane lanes and the address mux
// feed one output register, and busy never rises as the receiver cannot stall.
// Reset is asynchronous and active low; it clears the strobe and the registers.
module vga_graphics_write_path_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  vgw_pkg::in_t                  in_i,
  output logic                          result_valid_o,
  output vgw_pkg::out_t                 result_o,
  input  logic                          cfg_we_i,
  input  logic [vgw_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [vgw_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import vgw_pkg::*;

`include "vga_graphics_write_path_top_assert.svh"

  wr_mode_e   write_mode_q;
  logic [3:0] sr_value_q;
  logic [3:0] sr_enable_q;
  logic [4:0] rot_func_q;
  logic [7:0] bit_mask_q;
  logic [3:0] seq_mode_q;
  logic [3:0] misc_q;
  logic       page_select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_mode_q  <= WrMode0;
      sr_value_q    <= '0;
      sr_enable_q   <= '0;
      rot_func_q    <= '0;
      bit_mask_q    <= BitMaskReset;
      seq_mode_q    <= '0;
      misc_q        <= '0;
      page_select_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgWriteMode:      write_mode_q  <= wr_mode_e'(cfg_wdata_i[1:0]);
        CfgSetResetValue:  sr_value_q    <= cfg_wdata_i[3:0];
        CfgSetResetEnable: sr_enable_q   <= cfg_wdata_i[3:0];
        CfgRotateFunction: rot_func_q    <= cfg_wdata_i[4:0];
        CfgBitMask:        bit_mask_q    <= cfg_wdata_i;
        CfgSeqMemMode:     seq_mode_q    <= cfg_wdata_i[3:0];
        CfgGraphicsMisc:   misc_q        <= cfg_wdata_i[3:0];
        CfgPageSelect:     page_select_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic                   accept;
  logic [2*ByteW-1:0]     rot_wide;
  logic [ByteW-1:0]       rot;
  lane_ctrl_t             lane_ctrl;
  logic [NumPlanes-1:0]   sr_val;
  logic [NumPlanes-1:0]   sr_en;
  addr_cfg_t              addr_cfg;
  out_t                   result_d;
  out_t                   result_q;
  logic                   valid_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign rot_wide = {in_i.cpu_data, in_i.cpu_data} >> rot_func_q[2:0];
  assign rot      = rot_wide[ByteW-1:0];

  always_comb begin
    lane_ctrl.op   = alu_op_e'(rot_func_q[4:3]);
    lane_ctrl.fill = '0;
    lane_ctrl.mask = bit_mask_q;
    sr_val         = sr_value_q;
    sr_en          = '1;
    case (write_mode_q)
      WrMode0: begin
        lane_ctrl.fill = rot;
        sr_en          = sr_enable_q;
      end
      WrMode1: begin
        lane_ctrl.mask = '0;
        sr_val         = '0;
        sr_en          = '0;
      end
      WrMode2: begin
        sr_val = in_i.cpu_data[3:0];
      end
      default: begin
        lane_ctrl.mask = bit_mask_q & rot;
      end
    endcase
  end

  for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
    vgw_lane u_lane (
      .ctrl_i   (lane_ctrl),
      .sr_val_i (sr_val[p]),
      .sr_en_i  (sr_en[p]),
      .latch_i  (in_i.latch_bytes[p*ByteW +: ByteW]),
      .byte_o   (result_d.plane_bytes[p*ByteW +: ByteW])
    );
  end

  assign addr_cfg.seq_mode    = seq_mode_q;
  assign addr_cfg.misc        = misc_q;
  assign addr_cfg.page_select = page_select_q;

  vgw_addr u_addr (
    .cfg_i           (addr_cfg),
    .cpu_address_i   (in_i.cpu_address),
    .map_address_o   (result_d.map_address),
    .plane_enables_o (result_d.plane_enables)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q <= '0;
    end else if (accept) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

  `VGW_ASSERT_IMPL(a_strobe_has_transfer, clk_i, rst_ni, valid_q, $past(accept))
  `VGW_ASSERT_IMPL(a_transfer_gives_strobe, clk_i, rst_ni,
    $past(rst_ni) && $past(accept), valid_q)
  `VGW_ASSERT_IMPL(a_planes_written, clk_i, rst_ni, valid_q, result_q.plane_enables != '0)
  `VGW_ASSERT_IMPL(a_chain4_one_plane, clk_i, rst_ni,
    valid_q && seq_mode_q[3] && $stable(seq_mode_q), $onehot(result_q.plane_enables))

endmodule
